/* hdl/mssh_pkg.sv */
// Shared widths, result codes and register map for the moving sphere-sphere hit pipeline.
// No dependencies; every other file of the block uses it.
package mssh_pkg;

   localparam int FRAC_BITS = 16;

   localparam int IN_W   = 32;               // offsets and velocities
   localparam int RAD_W  = 31;               // radii
   localparam int STAT_W = 2;
   localparam int TIME_W = 32;

   localparam int MAG_W  = 32;               // magnitudes of offset and relative velocity
   localparam int PR_W   = 2 * MAG_W;        // one exact product
   localparam int A_W    = PR_W + 2;         // v.v, sum of three squares
   localparam int NB_W   = PR_W + 1;         // -b, sum of three products
   localparam int C_W    = PR_W;             // s.s - r*r
   localparam int NBH_W  = NB_W - MAG_W;     // upper limb of -b
   localparam int AH_W   = A_W - MAG_W;      // upper limb of a
   localparam int CH_W   = C_W - MAG_W;      // upper limb of c
   localparam int D_W    = A_W + C_W;        // b*b and a*c
   localparam int R_W    = D_W / 2;          // square root
   localparam int SQ_N   = R_W;              // root bits, one per stage
   localparam int SQR_W  = R_W + 3;          // root remainder
   localparam int NUM_W  = NB_W + FRAC_BITS; // dividend
   localparam int DV_N   = TIME_W;           // quotient bits, one per stage

   localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERLAP = 2'd1;
   localparam logic [STAT_W-1:0] ST_AHEAD   = 2'd2;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_THR = 1'b0;      // register index, paddr[2]
   localparam logic [CSR_DW-1:0] THR_RESET = 32'd1;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [NB_W-1:0]   nb;
      logic [A_W-1:0]    a;
   } sq_meta_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              sat;
      logic [A_W-1:0]    a;
   } dv_meta_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TIME_W-1:0] hit_time;
   } out_word_type;

endpackage

/* hdl/mssh_req_if.sv */
// Input channel: one sphere pair per word, valid/ready handshake.
// Depends on mssh_pkg for field widths.
interface mssh_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mssh_pkg::IN_W-1:0]   offset_x;
   logic signed [mssh_pkg::IN_W-1:0]   offset_y;
   logic signed [mssh_pkg::IN_W-1:0]   offset_z;
   logic signed [mssh_pkg::IN_W-1:0]   vel_a_x;
   logic signed [mssh_pkg::IN_W-1:0]   vel_a_y;
   logic signed [mssh_pkg::IN_W-1:0]   vel_a_z;
   logic signed [mssh_pkg::IN_W-1:0]   vel_b_x;
   logic signed [mssh_pkg::IN_W-1:0]   vel_b_y;
   logic signed [mssh_pkg::IN_W-1:0]   vel_b_z;
   logic        [mssh_pkg::RAD_W-1:0]  radius_a;
   logic        [mssh_pkg::RAD_W-1:0]  radius_b;

   modport source (output valid, offset_x, offset_y, offset_z, vel_a_x, vel_a_y, vel_a_z,
                   vel_b_x, vel_b_y, vel_b_z, radius_a, radius_b, input ready);
   modport sink   (input valid, offset_x, offset_y, offset_z, vel_a_x, vel_a_y, vel_a_z,
                   vel_b_x, vel_b_y, vel_b_z, radius_a, radius_b, output ready);
endinterface

/* hdl/mssh_rsp_if.sv */
// Result channel: hit status and contact time per word, valid/ready handshake.
// Depends on mssh_pkg for field widths.
interface mssh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mssh_pkg::STAT_W-1:0]        hit_status;
   logic [mssh_pkg::TIME_W-1:0]        hit_time;

   modport source (output valid, hit_status, hit_time, input ready);
   modport sink   (input valid, hit_status, hit_time, output ready);
endinterface

/* hdl/moving_sphere_sphere_hit_top.sv */
// Moving sphere-sphere first contact test: a fully pipelined datapath with an APB threshold reg.
// Depends on mssh_pkg, mssh_req_if and mssh_rsp_if.
//
// Takes one pair per clock while the pipeline is not held and returns one word per pair, in order:
// 7 stages form the exact products and b*b - a*c, 65 stages take the square root one bit
// per stage, 1 stage forms the dividend, and 32 stages divide one quotient bit per stage.
// A two-word output queue holds finished results; when both entries are taken the whole
// pipeline holds and ready drops, and it resumes once a word is read. ready does not
// depend on the result side's ready in the same cycle. still_threshold is at byte
// address 0 and should be written only while no pair is in flight.
module moving_sphere_sphere_hit_top (
   input  logic                          clock,
   input  logic                          reset,
   mssh_req_if.sink                      req_bus,
   mssh_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mssh_pkg::CSR_AW-1:0]   paddr,
   input  logic [mssh_pkg::CSR_DW-1:0]   pwdata,
   output logic [mssh_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import mssh_pkg::*;

   logic               en;
   logic [1:0]         cnt_ff, cnt_in;
   logic [CSR_DW-1:0]  thr_ff;
   out_word_type       e0_ff, e0_in, e1_ff, e1_in;

   // stage 1
   logic [IN_W-1:0]    s_in  [3];
   logic [IN_W-1:0]    va_in [3];
   logic [IN_W-1:0]    vb_in [3];
   logic [IN_W:0]      rv_in [3];
   logic               v1_ff;
   logic [MAG_W-1:0]   ms1_ff [3], ms1_in [3];
   logic [MAG_W-1:0]   mv1_ff [3], mv1_in [3];
   logic [2:0]         opp1_ff, opp1_in;
   logic [MAG_W-1:0]   r1_ff, r1_in;
   // stage 2
   logic               v2_ff;
   logic [PR_W-1:0]    sqs2_ff [3];
   logic [PR_W-1:0]    sqv2_ff [3];
   logic [PR_W-1:0]    pr2_ff [3];
   logic [PR_W-1:0]    rr2_ff;
   logic [2:0]         opp2_ff;
   // stage 3
   logic               v3_ff;
   logic [C_W-1:0]     ss3_ff, rr3_ff;
   logic [A_W-1:0]     a3_ff;
   logic [NB_W-1:0]    pos3_ff, neg3_ff, pos3_in, neg3_in;
   // stage 4
   logic               v4_ff;
   logic [STAT_W-1:0]  st4_ff, st4_in;
   logic [C_W-1:0]     c4_ff;
   logic [A_W-1:0]     a4_ff;
   logic [NB_W-1:0]    nb4_ff;
   // stage 5
   logic               v5_ff;
   logic [STAT_W-1:0]  st5_ff;
   logic [NB_W-1:0]    nb5_ff;
   logic [A_W-1:0]     a5_ff;
   logic [2*NBH_W-1:0] hh5_ff;
   logic [NBH_W+MAG_W-1:0] hl5_ff;
   logic [PR_W-1:0]    ll5_ff;
   logic [AH_W+CH_W-1:0] ahch5_ff;
   logic [AH_W+MAG_W-1:0] ahcl5_ff;
   logic [MAG_W+CH_W-1:0] alch5_ff;
   logic [PR_W-1:0]    alcl5_ff;
   // stage 6
   logic               v6_ff;
   logic [STAT_W-1:0]  st6_ff;
   logic [NB_W-1:0]    nb6_ff;
   logic [A_W-1:0]     a6_ff;
   logic [D_W-1:0]     bb6_ff, ac6_ff;
   // square root stages; entry 0 is stage 7
   logic [SQ_N:0]      sqv_ff;
   logic [D_W-1:0]     sq_d_ff    [SQ_N+1], sq_d_in    [SQ_N+1];
   logic [SQR_W-1:0]   sq_rem_ff  [SQ_N+1], sq_rem_in  [SQ_N+1];
   logic [R_W-1:0]     sq_root_ff [SQ_N+1], sq_root_in [SQ_N+1];
   sq_meta_type        sq_meta_ff [SQ_N+1], sq_meta_in [SQ_N+1];
   // divide stages; entry 0 forms the dividend
   logic [DV_N:0]      dvv_ff;
   logic [A_W-1:0]     dv_rem_ff  [DV_N+1], dv_rem_in  [DV_N+1];
   logic [TIME_W-1:0]  dv_low_ff  [DV_N+1], dv_low_in  [DV_N+1];
   logic [TIME_W-1:0]  dv_q_ff    [DV_N+1], dv_q_in    [DV_N+1];
   dv_meta_type        dv_meta_ff [DV_N+1], dv_meta_in [DV_N+1];

   out_word_type       done_word;
   logic               push, pop;

   assign en            = (cnt_ff != 2'd2);
   assign req_bus.ready = en;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_THR) ? thr_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_THR) begin
         thr_ff <= pwdata;
      end
   end

   // ---------------- stage 1: magnitudes and signs ----------------
   assign s_in[0]  = req_bus.offset_x;
   assign s_in[1]  = req_bus.offset_y;
   assign s_in[2]  = req_bus.offset_z;
   assign va_in[0] = req_bus.vel_a_x;
   assign va_in[1] = req_bus.vel_a_y;
   assign va_in[2] = req_bus.vel_a_z;
   assign vb_in[0] = req_bus.vel_b_x;
   assign vb_in[1] = req_bus.vel_b_y;
   assign vb_in[2] = req_bus.vel_b_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rv_in[i]  = {va_in[i][IN_W-1], va_in[i]} - {vb_in[i][IN_W-1], vb_in[i]};
         ms1_in[i] = s_in[i][IN_W-1] ? (-s_in[i]) : s_in[i];
         mv1_in[i] = rv_in[i][IN_W] ? MAG_W'(-rv_in[i]) : MAG_W'(rv_in[i]);
         opp1_in[i] = rv_in[i][IN_W] != s_in[i][IN_W-1];
      end
      r1_in = MAG_W'(req_bus.radius_a) + MAG_W'(req_bus.radius_b);
   end

   // ---------------- stages 3 to 4: sums and early decisions ----------------
   always_comb begin
      pos3_in = '0;
      neg3_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (opp2_ff[i]) begin
            neg3_in = neg3_in + NB_W'(pr2_ff[i]);
         end else begin
            pos3_in = pos3_in + NB_W'(pr2_ff[i]);
         end
      end
   end

   always_comb begin
      if (ss3_ff < rr3_ff) begin
         st4_in = ST_OVERLAP;
      end else if (a3_ff == '0 || a3_ff < A_W'(thr_ff) || pos3_ff >= neg3_ff) begin
         st4_in = ST_NONE;
      end else begin
         st4_in = ST_AHEAD;
      end
   end

   // ---------------- stage 7 and square root stages ----------------
   always_comb begin
      logic [SQR_W-1:0] t;
      logic [SQR_W-1:0] trial;
      logic             ge;
      sq_d_in[0]           = bb6_ff - ac6_ff;
      sq_rem_in[0]         = '0;
      sq_root_in[0]        = '0;
      sq_meta_in[0].nb     = nb6_ff;
      sq_meta_in[0].a      = a6_ff;
      sq_meta_in[0].status = (st6_ff == ST_AHEAD && bb6_ff < ac6_ff) ? ST_NONE : st6_ff;
      for (int k = 0; k < SQ_N; k++) begin
         t     = {sq_rem_ff[k][SQR_W-3:0], sq_d_ff[k][D_W-1 -: 2]};
         trial = SQR_W'({sq_root_ff[k], 2'b01});
         ge    = t >= trial;
         sq_rem_in[k+1]  = ge ? (t - trial) : t;
         sq_root_in[k+1] = {sq_root_ff[k][R_W-2:0], ge};
         sq_d_in[k+1]    = sq_d_ff[k] << 2;
         sq_meta_in[k+1] = sq_meta_ff[k];
      end
   end

   // ---------------- dividend and divide stages ----------------
   always_comb begin
      logic [NB_W-1:0]  diff;
      logic [NUM_W-1:0] num;
      logic [A_W-1:0]   hi;
      logic [A_W:0]     t;
      logic             ge;
      diff = sq_meta_ff[SQ_N].nb - NB_W'(sq_root_ff[SQ_N]);
      num  = NUM_W'(diff) << FRAC_BITS;
      hi   = A_W'(num[NUM_W-1:TIME_W]);
      dv_meta_in[0].status = sq_meta_ff[SQ_N].status;
      dv_meta_in[0].a      = sq_meta_ff[SQ_N].a;
      dv_meta_in[0].sat    = hi >= sq_meta_ff[SQ_N].a;
      dv_rem_in[0]         = (hi >= sq_meta_ff[SQ_N].a) ? '0 : hi;
      dv_low_in[0]         = num[TIME_W-1:0];
      dv_q_in[0]           = '0;
      for (int k = 0; k < DV_N; k++) begin
         t  = {dv_rem_ff[k], dv_low_ff[k][TIME_W-1]};
         ge = t >= {1'b0, dv_meta_ff[k].a};
         dv_rem_in[k+1]  = ge ? A_W'(t - {1'b0, dv_meta_ff[k].a}) : A_W'(t);
         dv_low_in[k+1]  = dv_low_ff[k] << 1;
         dv_q_in[k+1]    = {dv_q_ff[k][TIME_W-2:0], ge};
         dv_meta_in[k+1] = dv_meta_ff[k];
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         ms1_ff  <= ms1_in;
         mv1_ff  <= mv1_in;
         opp1_ff <= opp1_in;
         r1_ff   <= r1_in;

         for (int i = 0; i < 3; i++) begin
            sqs2_ff[i] <= PR_W'(ms1_ff[i]) * PR_W'(ms1_ff[i]);
            sqv2_ff[i] <= PR_W'(mv1_ff[i]) * PR_W'(mv1_ff[i]);
            pr2_ff[i]  <= PR_W'(mv1_ff[i]) * PR_W'(ms1_ff[i]);
         end
         rr2_ff  <= PR_W'(r1_ff) * PR_W'(r1_ff);
         opp2_ff <= opp1_ff;

         ss3_ff  <= sqs2_ff[0] + sqs2_ff[1] + sqs2_ff[2];
         rr3_ff  <= rr2_ff;
         a3_ff   <= A_W'(sqv2_ff[0]) + A_W'(sqv2_ff[1]) + A_W'(sqv2_ff[2]);
         pos3_ff <= pos3_in;
         neg3_ff <= neg3_in;

         st4_ff <= st4_in;
         c4_ff  <= ss3_ff - rr3_ff;
         a4_ff  <= a3_ff;
         nb4_ff <= neg3_ff - pos3_ff;

         // limb products for b*b and a*c
         st5_ff   <= st4_ff;
         nb5_ff   <= nb4_ff;
         a5_ff    <= a4_ff;
         hh5_ff   <= (2*NBH_W)'(nb4_ff[NB_W-1:MAG_W]) * (2*NBH_W)'(nb4_ff[NB_W-1:MAG_W]);
         hl5_ff   <= (NBH_W+MAG_W)'(nb4_ff[NB_W-1:MAG_W]) * (NBH_W+MAG_W)'(nb4_ff[MAG_W-1:0]);
         ll5_ff   <= PR_W'(nb4_ff[MAG_W-1:0]) * PR_W'(nb4_ff[MAG_W-1:0]);
         ahch5_ff <= (AH_W+CH_W)'(a4_ff[A_W-1:MAG_W]) * (AH_W+CH_W)'(c4_ff[C_W-1:MAG_W]);
         ahcl5_ff <= (AH_W+MAG_W)'(a4_ff[A_W-1:MAG_W]) * (AH_W+MAG_W)'(c4_ff[MAG_W-1:0]);
         alch5_ff <= (MAG_W+CH_W)'(a4_ff[MAG_W-1:0]) * (MAG_W+CH_W)'(c4_ff[C_W-1:MAG_W]);
         alcl5_ff <= PR_W'(a4_ff[MAG_W-1:0]) * PR_W'(c4_ff[MAG_W-1:0]);

         st6_ff <= st5_ff;
         nb6_ff <= nb5_ff;
         a6_ff  <= a5_ff;
         bb6_ff <= (D_W'(hh5_ff) << (2*MAG_W)) + (D_W'(hl5_ff) << (MAG_W+1))
                   + D_W'(ll5_ff);
         ac6_ff <= (D_W'(ahch5_ff) << (2*MAG_W)) + (D_W'(ahcl5_ff) << MAG_W)
                   + (D_W'(alch5_ff) << MAG_W) + D_W'(alcl5_ff);

         sq_d_ff    <= sq_d_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_meta_ff <= sq_meta_in;

         dv_rem_ff  <= dv_rem_in;
         dv_low_ff  <= dv_low_in;
         dv_q_ff    <= dv_q_in;
         dv_meta_ff <= dv_meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         sqv_ff <= '0;
         dvv_ff <= '0;
      end else if (en) begin
         v1_ff  <= req_bus.valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         sqv_ff <= {sqv_ff[SQ_N-1:0], v6_ff};
         dvv_ff <= {dvv_ff[DV_N-1:0], sqv_ff[SQ_N]};
      end
   end

   // ---------------- output queue ----------------
   always_comb begin
      done_word.status = dv_meta_ff[DV_N].status;
      if (dv_meta_ff[DV_N].status != ST_AHEAD) begin
         done_word.hit_time = '0;
      end else if (dv_meta_ff[DV_N].sat) begin
         done_word.hit_time = '1;
      end else begin
         done_word.hit_time = dv_q_ff[DV_N];
      end
   end

   assign push = en && dvv_ff[DV_N];
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      cnt_in = cnt_ff;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      if (pop) begin
         e0_in  = e1_ff;
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            e0_in = done_word;
         end else begin
            e1_in = done_word;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign rsp_bus.valid      = (cnt_ff != 2'd0);
   assign rsp_bus.hit_status = e0_ff.status;
   assign rsp_bus.hit_time   = e0_ff.hit_time;

   // ---------------- assertions ----------------
   // a word that is not a contact ahead carries time zero
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.hit_status != ST_AHEAD) |-> rsp_bus.hit_time == '0)
      else $error("nonzero time on a word without contact ahead");

   // a full queue stays full until a word is read
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("output queue changed without a read");

   // a held pipeline keeps the end of the root stages and the divide stage valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(sq_root_ff[SQ_N]) && $stable(dvv_ff)))
      else $error("pipeline moved while held");

   // the queue never overflows past two words
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push)
      else $error("push into a full output queue");

endmodule

/* test/mssh_hit_checker.sv */
// Scoreboard for the moving sphere-sphere hit pipeline: predicts each pair's result and compares.
// Depends on mssh_pkg, mssh_req_if and mssh_rsp_if; watches the APB writes for the threshold.
module mssh_hit_checker (
   input  logic                        clock,
   input  logic                        reset,
   mssh_req_if                         req,
   mssh_rsp_if                         rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [mssh_pkg::CSR_AW-1:0] paddr,
   input  logic [mssh_pkg::CSR_DW-1:0] pwdata,
   output int                          fail_count,
   output int                          pending
);
   import mssh_pkg::*;

   typedef logic [191:0] wide_type;

   logic [CSR_DW-1:0] still_thr;
   out_word_type      expected_hits[$];

   function automatic longint unsigned abs64(longint x);
      return (x < 0) ? longint'(-x) : x;
   endfunction

   function automatic out_word_type predict_contact(
      logic signed [IN_W-1:0] ofs[3], logic signed [IN_W-1:0] va[3],
      logic signed [IN_W-1:0] vb[3], logic [RAD_W-1:0] ra, logic [RAD_W-1:0] rb,
      logic [CSR_DW-1:0] thr);
      out_word_type res;
      wide_type ss, rr, r, c, a, pos, neg, nb, bb, ac, d, root, cand, num, ms, mv;
      longint s, v;
      int k;
      res.status = ST_NONE;
      res.hit_time = '0;
      ss = 0; a = 0; pos = 0; neg = 0;
      r = wide_type'(ra) + wide_type'(rb);
      rr = r * r;
      for (k = 0; k < 3; k++) begin
         ms = wide_type'(abs64(longint'(ofs[k])));
         ss = ss + ms * ms;
      end
      if (ss < rr) begin
         res.status = ST_OVERLAP;
         return res;
      end
      c = ss - rr;
      for (k = 0; k < 3; k++) begin
         s = longint'(ofs[k]);
         v = longint'(va[k]) - longint'(vb[k]);
         ms = wide_type'(abs64(s));
         mv = wide_type'(abs64(v));
         a = a + mv * mv;
         if ((v < 0) != (s < 0)) neg = neg + mv * ms;
         else pos = pos + mv * ms;
      end
      // a == 0 misses even with a zero threshold
      if (a == 0 || a < wide_type'(thr)) return res;
      if (pos >= neg) return res;
      nb = neg - pos;
      bb = nb * nb;
      ac = a * c;
      if (bb < ac) return res;
      d = bb - ac;
      root = 0;
      for (k = 67; k >= 0; k--) begin
         cand = root | (wide_type'(1) << k);
         if (cand * cand <= d) root = cand;
      end
      num = (nb - root) << FRAC_BITS;
      res.status = ST_AHEAD;
      if (num >= (a << 32)) res.hit_time = '1;
      else res.hit_time = TIME_W'(num / a);
      return res;
   endfunction

   assign pending = expected_hits.size();

   always @(posedge clock) begin
      logic signed [IN_W-1:0] ofs[3], va[3], vb[3];
      out_word_type want;
      if (reset) begin
         still_thr <= THR_RESET;
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_THR)
            still_thr <= pwdata;
         if (req.valid && req.ready) begin
            ofs = '{req.offset_x, req.offset_y, req.offset_z};
            va  = '{req.vel_a_x, req.vel_a_y, req.vel_a_z};
            vb  = '{req.vel_b_x, req.vel_b_y, req.vel_b_z};
            expected_hits = {expected_hits, predict_contact(ofs, va, vb, req.radius_a,
                                                            req.radius_b, still_thr)};
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_hits.size() == 0) begin
               $error("result word with nothing expected: status %0d time %h",
                      rsp.hit_status, rsp.hit_time);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hits.pop_front();
               if (want.status != rsp.hit_status || want.hit_time != rsp.hit_time) begin
                  if (want.status != rsp.hit_status)
                     $error("hit_status: expected %0d, actual %0d", want.status,
                            rsp.hit_status);
                  if (want.hit_time != rsp.hit_time)
                     $error("hit_time: expected %h, actual %h", want.hit_time,
                            rsp.hit_time);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* test/tb_moving_sphere_sphere_hit_top.sv */
// Stimulus and verdict for the moving sphere-sphere hit pipeline: directed and random pairs,
// random idling on both sides, threshold phases. Depends on mssh_pkg, both interfaces, the
// block and mssh_hit_checker.
module tb_moving_sphere_sphere_hit_top;
   import mssh_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int PAUSE = 120;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;
   int fail_count, pending;
   int req_words = 0, rsp_words = 0, idle_cycles = 0;
   bit burst = 0, long_hold = 0;
   logic [CSR_DW-1:0] thr_settings[5] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0};

   mssh_req_if req_if ();
   mssh_rsp_if rsp_if ();

   moving_sphere_sphere_hit_top DUT (
      .clock(clock), .reset(reset), .req_bus(req_if), .rsp_bus(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   mssh_hit_checker hit_checker (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   // word counters and an idle watchdog, settled by the next falling edge
   always @(posedge clock) begin
      if (req_if.valid && req_if.ready) req_words <= req_words + 1;
      if (rsp_if.valid && rsp_if.ready) rsp_words <= rsp_words + 1;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_pair(input logic [31:0] ox, oy, oz, vax, vay, vaz, vbx, vby, vbz,
                            input logic [30:0] ra, rb);
      int gap, target;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.offset_x <= ox; req_if.offset_y <= oy; req_if.offset_z <= oz;
      req_if.vel_a_x <= vax; req_if.vel_a_y <= vay; req_if.vel_a_z <= vaz;
      req_if.vel_b_x <= vbx; req_if.vel_b_y <= vby; req_if.vel_b_z <= vbz;
      req_if.radius_a <= ra; req_if.radius_b <= rb;
      req_if.valid <= 1'b1;
      target = req_words + 1;
      do @(negedge clock); while (req_words < target);
   endtask

   function automatic logic [31:0] scaled(int w);
      return $signed($urandom) >>> (32 - w);
   endfunction

   task automatic random_pair();
      logic [31:0] ofs[3], rel[3], vb[3];
      logic [30:0] ra, rb;
      int w, sh, k;
      if ($urandom_range(0, 9) < 2) begin
         // noise: any bit pattern
         send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
         return;
      end
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 31);
      sh = $urandom_range(0, 10);
      for (k = 0; k < 3; k++) begin
         ofs[k] = scaled(w);
         // mostly closing in, with some sideways noise
         rel[k] = -($signed(ofs[k]) >>> sh) + scaled($urandom_range(1, w));
         vb[k] = scaled($urandom_range(1, 31));
      end
      ra = 31'($urandom) >> (32 - w);
      rb = 31'($urandom) >> (32 - w);
      send_pair(ofs[0], ofs[1], ofs[2], vb[0] + rel[0], vb[1] + rel[1], vb[2] + rel[2],
                vb[0], vb[1], vb[2], ra, rb);
   endtask

   task automatic csr_write(input logic [CSR_DW-1:0] value);
      req_if.valid <= 1'b0;
      wait (pending == 0);
      repeat (PAUSE) @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {CSR_IDX_THR, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // result side: random stalls, one long hold-off while the sender keeps going
   initial begin
      int stall, target;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 12);
         if (long_hold) begin
            stall = 400;
            long_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         target = rsp_words + 1;
         do @(negedge clock); while (rsp_words < target);
      end
   end

   initial begin
      int ph, n;
      req_if.valid = 1'b0;
      {req_if.offset_x, req_if.offset_y, req_if.offset_z} = '0;
      {req_if.vel_a_x, req_if.vel_a_y, req_if.vel_a_z} = '0;
      {req_if.vel_b_x, req_if.vel_b_y, req_if.vel_b_z} = '0;
      req_if.radius_a = '0; req_if.radius_b = '0;
      thr_settings[3] = $urandom;
      thr_settings[4] = $urandom_range(2, 4096);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, threshold at reset value
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd0);              // touching, still
      send_pair(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 31'h10000, 31'h8000); // overlap
      send_pair(32'h20000, 0, 0, 32'hFFFF0000, 0, 0, 0, 0, 0,
                31'h10000, 31'h10000);                                   // touching, closing
      send_pair(32'h40000, 0, 0, 32'h10000, 0, 0, 0, 0, 0,
                31'h10000, 31'h10000);                                   // moving apart
      send_pair(32'h40000, 32'h40000, 0, 0, 32'hFFFF0000, 0, 0, 0, 0,
                31'h100, 31'h100);                                       // glancing miss
      send_pair(32'h40000, 0, 0, 32'hFFFF0000, 0, 0, 0, 0, 0,
                31'h10000, 31'h10000);                                   // plain hit
      send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 0, 0, 0, 31'd0, 31'd0);                    // late contact
      send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                31'h7FFFFFFF, 31'h7FFFFFFF);                             // extremes, overlap
      send_pair(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000,
                32'h80000000, 0, 32'h7FFFFFFF, 31'd0, 31'd0);            // extreme speeds
      send_pair(32'h10, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 31'h1, 31'h1); // a = 1
      send_pair(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0,
                31'h7FFFFFFF, 31'h7FFFFFFF);                             // radius max
      send_pair(32'hFFFC0000, 0, 0, 32'h20000, 0, 0, 32'h10000, 0, 0,
                31'h8000, 31'h8000);                                     // negative offset hit
      send_pair(32'h40000, 32'hFFFF0000, 32'h8000, 32'hFFFF8000, 32'h4000, 0,
                32'h4000, 0, 32'hFFFFC000, 31'h1000, 31'h2000);
      send_pair(0, 0, 32'h10000, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 31'h8000, 31'h7FFF);

      for (ph = 0; ph < 6; ph++) begin
         if (ph > 0) csr_write(thr_settings[ph - 1]);
         for (n = 0; n < 240; n++) begin
            if (n % 80 == 0) burst = ($urandom_range(0, 2) == 0);
            if (ph == 1 && n == 60) long_hold = 1;
            random_pair();
         end
      end
      req_if.valid <= 1'b0;

      wait (pending == 0);
      repeat (PAUSE) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* filelist.f */
hdl/mssh_pkg.sv
hdl/mssh_req_if.sv
hdl/mssh_rsp_if.sv
hdl/moving_sphere_sphere_hit_top.sv
test/mssh_hit_checker.sv
test/tb_moving_sphere_sphere_hit_top.sv
